// ===== rtl/core/sqe_pkg.sv =====
package sqe_pkg;

  // Operation codes carried on func
  typedef enum logic [2:0] {
    FUNC_PUSH = 3'd0,
    FUNC_DUMP = 3'd1,
    FUNC_PEEK = 3'd2,
    FUNC_POP  = 3'd3,
    FUNC_SWAP = 3'd4
  } func_e;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_NOARG      = 3'd1,
    STAT_PEEK_EMPTY = 3'd2,
    STAT_POP_EMPTY  = 3'd3,
    STAT_SWAP_SHORT = 3'd4,
    STAT_FULL       = 3'd5
  } status_e;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_SWAP_A = 4'b0100,
    S_SWAP_B = 4'b1000
  } state_e;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

endpackage

// ===== rtl/core/sqe_mem.sv =====
module sqe_mem import sqe_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  word_t                    wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output word_t                    rdata0_o,
  output word_t                    rdata1_o
);

  word_t mem_q [DEPTH];
  word_t rdata0_q;
  word_t rdata1_q;

  // Write one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read two entries per cycle, registered
  always_ff @(posedge clk_i) begin
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ===== rtl/core/sqe_ctrl.sv =====
module sqe_ctrl import sqe_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               func_i,
  input  logic                     arg_present_i,
  input  logic signed [31:0]       push_value_i,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  output logic                     done_o,
  output logic signed [31:0]       data_o,
  output logic                     has_data_o,
  output logic [2:0]               status_o,
  output logic                     last_o,
  output logic                     mem_we_o,
  output logic [$clog2(DEPTH)-1:0] mem_waddr_o,
  output word_t                    mem_wdata_o,
  output logic [$clog2(DEPTH)-1:0] mem_raddr0_o,
  output logic [$clog2(DEPTH)-1:0] mem_raddr1_o,
  input  word_t                    mem_rdata0_i,
  input  word_t                    mem_rdata1_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  state_e        state_q, state_d;
  logic [AW-1:0] top_q, top_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] remain_q, remain_d;
  logic [AW-1:0] ptr_q, ptr_d;
  word_t         tmp_q, tmp_d;
  logic          queue_mode_q;

  logic          done_q, done_d;
  word_t         data_q, data_d;
  logic          has_q, has_d;
  status_e       status_q, status_d;
  logic          last_q, last_d;

  logic          accept;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail_slot;
  logic          empty;
  logic          full;

  assign accept = start && (state_q == S_IDLE);
  assign empty  = (count_q == '0);
  assign full   = (count_q == CW'(DEPTH));

  // Slot just below the bottom word, for queue-mode appends
  assign tail_sum  = (AW + 1)'(top_q) + (AW + 1)'(count_q);
  assign tail_slot = (tail_sum >= (AW + 1)'(DEPTH)) ?
                     AW'(tail_sum - (AW + 1)'(DEPTH)) : AW'(tail_sum);

  // Hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      queue_mode_q <= cfg_wdata_i;
    end
  end

  // Sequence each request
  always_comb begin
    state_d      = state_q;
    top_d        = top_q;
    count_d      = count_q;
    remain_d     = remain_q;
    ptr_d        = ptr_q;
    tmp_d        = tmp_q;
    done_d       = 1'b0;
    data_d       = '0;
    has_d        = 1'b0;
    status_d     = STAT_OK;
    last_d       = 1'b0;
    mem_we_o     = 1'b0;
    mem_waddr_o  = top_q;
    mem_wdata_o  = push_value_i;
    mem_raddr0_o = top_q;
    mem_raddr1_o = ptr_inc(top_q);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_PUSH: begin
              done_d = 1'b1;
              last_d = 1'b1;
              if (!arg_present_i) begin
                status_d = STAT_NOARG;
              end else if (full) begin
                status_d = STAT_FULL;
              end else begin
                mem_we_o = 1'b1;
                count_d  = count_q + CW'(1);
                if (queue_mode_q) begin
                  mem_waddr_o = tail_slot;
                end else begin
                  mem_waddr_o = ptr_dec(top_q);
                  top_d       = ptr_dec(top_q);
                end
              end
            end
            FUNC_DUMP, FUNC_PEEK: begin
              if (empty) begin
                done_d   = 1'b1;
                last_d   = 1'b1;
                status_d = (func_i == FUNC_PEEK) ? STAT_PEEK_EMPTY : STAT_OK;
              end else begin
                state_d  = S_READ;
                ptr_d    = ptr_inc(top_q);
                remain_d = (func_i == FUNC_PEEK) ? CW'(1) : count_q;
              end
            end
            FUNC_POP: begin
              done_d = 1'b1;
              last_d = 1'b1;
              if (empty) begin
                status_d = STAT_POP_EMPTY;
              end else begin
                top_d   = ptr_inc(top_q);
                count_d = count_q - CW'(1);
              end
            end
            FUNC_SWAP: begin
              if (count_q < CW'(2)) begin
                done_d   = 1'b1;
                last_d   = 1'b1;
                status_d = STAT_SWAP_SHORT;
              end else begin
                state_d = S_SWAP_A;
              end
            end
            default: begin
              done_d = 1'b1;
              last_d = 1'b1;
            end
          endcase
        end
      end
      // Emit one stored word per cycle and fetch the next
      S_READ: begin
        mem_raddr0_o = ptr_q;
        ptr_d        = ptr_inc(ptr_q);
        remain_d     = remain_q - CW'(1);
        done_d       = 1'b1;
        data_d       = mem_rdata0_i;
        has_d        = 1'b1;
        if (remain_q == CW'(1)) begin
          last_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      // Overwrite the top with the second word, keep the old top
      S_SWAP_A: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = top_q;
        mem_wdata_o = mem_rdata1_i;
        tmp_d       = mem_rdata0_i;
        state_d     = S_SWAP_B;
      end
      // Write the old top into the second slot
      S_SWAP_B: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_inc(top_q);
        mem_wdata_o = tmp_q;
        done_d      = 1'b1;
        last_d      = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      top_q    <= '0;
      count_q  <= '0;
      remain_q <= '0;
      ptr_q    <= '0;
      done_q   <= 1'b0;
      has_q    <= 1'b0;
      last_q   <= 1'b0;
      status_q <= STAT_OK;
    end else begin
      state_q  <= state_d;
      top_q    <= top_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      ptr_q    <= ptr_d;
      done_q   <= done_d;
      has_q    <= has_d;
      last_q   <= last_d;
      status_q <= status_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tmp_q  <= tmp_d;
    data_q <= data_d;
  end

  assign busy       = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign data_o     = data_q;
  assign has_data_o = has_q;
  assign status_o   = status_q;
  assign last_o     = last_q;

endmodule

// ===== rtl/core/stack_queue_engine_core.sv =====
// Bounded word stack with a queue mode, held in a circular buffer in one
// dual-read, single-write synchronous memory.
// Requests: drive func_i, arg_present_i and push_value_i with start high;
// the request is taken at a clock edge where busy is low.
// Results: each appears for one cycle with done_o high; last_o marks the
// final result of a request. The receiver cannot stall, so results are
// never held back.
// Sequencing, from the accepting edge to the edge that drops busy:
//   push, pop, failed checks, unused codes: never busy, result next cycle
//   peek: busy in S_READ (registered memory read), result registered from it
//   swap: busy in S_SWAP_A, S_SWAP_B (two writes, single write port)
//   dump of N words: busy in S_READ, one word per cycle, top to bottom
// User writes queue_mode by cfg_we_i/cfg_wdata_i only while idle; unchecked.
// Reset empties the store and selects stack mode; memory contents are
// left as they are, since only held words are ever read.
module stack_queue_engine_core import sqe_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         func_i,
  input  logic               arg_present_i,
  input  logic signed [31:0] push_value_i,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  output logic               done_o,
  output logic signed [31:0] data_o,
  output logic               has_data_o,
  output logic [2:0]         status_o,
  output logic               last_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;
  logic [AW-1:0] mem_raddr0;
  logic [AW-1:0] mem_raddr1;
  word_t         mem_rdata0;
  word_t         mem_rdata1;

  sqe_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .arg_present_i(arg_present_i),
    .push_value_i (push_value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .data_o       (data_o),
    .has_data_o   (has_data_o),
    .status_o     (status_o),
    .last_o       (last_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr0_o (mem_raddr0),
    .mem_raddr1_o (mem_raddr1),
    .mem_rdata0_i (mem_rdata0),
    .mem_rdata1_i (mem_rdata1)
  );

  sqe_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr0_i(mem_raddr0),
    .raddr1_i(mem_raddr1),
    .rdata0_o(mem_rdata0),
    .rdata1_o(mem_rdata1)
  );

endmodule

// ===== rtl/core/sqe_checker.sv =====
module sqe_checker import sqe_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [2:0]         func_i,
  input logic               done_o,
  input logic signed [31:0] data_o,
  input logic               has_data_o,
  input logic [2:0]         status_o,
  input logic               last_o
);

  // Push and pop answer on the next cycle with a single final result
  a_single_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (func_i == FUNC_PUSH || func_i == FUNC_POP))
      |=> (done_o && last_o))
    else $error("push/pop result missing on the following cycle");

  // A non-final result means more words are still being read out
  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !last_o) |-> busy)
    else $error("non-final result while idle");

  // Flags show only alongside the strobe
  a_flags_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> (!has_data_o && !last_o))
    else $error("result flags without strobe");

  // Stored words come only with an ok status, empty results carry zero
  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && has_data_o) |-> (status_o == STAT_OK))
    else $error("stored word with error status");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !has_data_o) |-> (data_o == 32'sd0))
    else $error("non-zero data without stored word");

endmodule

bind stack_queue_engine_core sqe_checker u_sqe_checker (.*);

// ===== dv/stack_queue_engine_core_tb.sv =====
`timescale 1ns / 1ps

module stack_queue_engine_core_tb;
  import sqe_pkg::*;

  localparam int DEPTH = 64;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE_CYCLES = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_SEGMENTS = 9;
  localparam int SEGMENT_REQUESTS = 18;
  localparam word_t WORD_MAX = 32'h7fff_ffff;
  localparam word_t WORD_MIN = 32'h8000_0000;

  typedef struct {
    word_t      data;
    logic       has_data;
    logic [2:0] status;
    logic       last;
  } stack_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  func_i = 3'(FUNC_PUSH);
  logic        arg_present_i = 1'b0;
  word_t       push_value_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        done_o;
  word_t       data_o;
  logic        has_data_o;
  logic [2:0]  status_o;
  logic        last_o;

  // Shadow of the store, its pointers and the mode register
  word_t       shadow_words [DEPTH];
  logic [5:0]  shadow_top = '0;
  int          shadow_count = 0;
  logic        shadow_queue_mode = 1'b0;

  stack_result_t pending_results [$];
  int          error_count = 0;
  int          send_gap_pct = 0;
  int          quiet_cycles = 0;

  stack_queue_engine_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .arg_present_i(arg_present_i),
    .push_value_i (push_value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .data_o       (data_o),
    .has_data_o   (has_data_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Work out the results of one accepted request and advance the shadow
  function automatic void predict_stack_op(logic [2:0] op, logic arg, word_t value);
    stack_result_t res;
    word_t         held;
    logic [5:0]    pos;
    res = '{data: '0, has_data: 1'b0, status: STAT_OK, last: 1'b1};
    case (op)
      FUNC_PUSH: begin
        if (!arg) begin
          res.status = STAT_NOARG;
        end else if (shadow_count >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          if (shadow_queue_mode) begin
            pos = shadow_top + 6'(shadow_count);
            shadow_words[pos] = value;
          end else begin
            shadow_top = shadow_top - 6'd1;
            shadow_words[shadow_top] = value;
          end
          shadow_count++;
        end
        pending_results.push_back(res);
      end
      FUNC_DUMP: begin
        if (shadow_count == 0) begin
          pending_results.push_back(res);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            res.data = shadow_words[shadow_top + 6'(i)];
            res.has_data = 1'b1;
            res.last = (i == shadow_count - 1);
            pending_results.push_back(res);
          end
        end
      end
      FUNC_PEEK: begin
        if (shadow_count == 0) begin
          res.status = STAT_PEEK_EMPTY;
        end else begin
          res.data = shadow_words[shadow_top];
          res.has_data = 1'b1;
        end
        pending_results.push_back(res);
      end
      FUNC_POP: begin
        if (shadow_count == 0) begin
          res.status = STAT_POP_EMPTY;
        end else begin
          shadow_top = shadow_top + 6'd1;
          shadow_count--;
        end
        pending_results.push_back(res);
      end
      FUNC_SWAP: begin
        if (shadow_count < 2) begin
          res.status = STAT_SWAP_SHORT;
        end else begin
          pos = shadow_top + 6'd1;
          held = shadow_words[shadow_top];
          shadow_words[shadow_top] = shadow_words[pos];
          shadow_words[pos] = held;
        end
        pending_results.push_back(res);
      end
      default: begin
        pending_results.push_back(res);
      end
    endcase
  endfunction

  // Send one request, idling first at the current gap rate
  task automatic issue_request(input logic [2:0] op, input logic arg, input word_t value);
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    func_i <= op;
    arg_present_i <= arg;
    push_value_i <= value;
    do @(posedge clk_i); while (busy);
    predict_stack_op(op, arg, value);
    @(negedge clk_i);
  endtask

  task automatic push_word(input word_t value);
    issue_request(FUNC_PUSH, 1'b1, value);
  endtask

  // Hold off until every expected result is in and the block has settled
  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_queue_mode(input logic mode);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    shadow_queue_mode = mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Every failing check on an empty store, plus the unused codes
  task automatic test_empty_store();
    issue_request(FUNC_PEEK, 1'b1, WORD_MAX);
    issue_request(FUNC_POP, 1'b0, '0);
    issue_request(FUNC_SWAP, 1'b1, WORD_MIN);
    issue_request(FUNC_DUMP, 1'b0, '1);
    issue_request(FUNC_PUSH, 1'b0, 32'h1234_5678);
    for (int k = 1; k <= 3; k++) begin
      issue_request(3'(FUNC_SWAP) + 3'(k), 1'(k), word_t'($urandom));
    end
  endtask

  // Extreme words through every operation in stack mode
  task automatic test_stack_extremes();
    push_word(WORD_MAX);
    issue_request(FUNC_SWAP, 1'b0, '0);
    push_word(WORD_MIN);
    push_word('0);
    push_word('1);
    issue_request(FUNC_PEEK, 1'b0, '0);
    issue_request(FUNC_SWAP, 1'b0, '0);
    issue_request(FUNC_PEEK, 1'b0, '0);
    issue_request(FUNC_DUMP, 1'b1, WORD_MAX);
    issue_request(FUNC_POP, 1'b1, '1);
    repeat (4) issue_request(FUNC_POP, 1'b0, '0);
    issue_request(FUNC_DUMP, 1'b0, '0);
  endtask

  // Fill the store, hit the full check, dump it whole and empty it again
  task automatic test_full_store();
    while (shadow_count < DEPTH) push_word(word_t'($urandom));
    push_word(word_t'($urandom));
    issue_request(FUNC_PUSH, 1'b0, word_t'($urandom));
    issue_request(FUNC_PEEK, 1'b0, '0);
    issue_request(FUNC_DUMP, 1'b0, '0);
    while (shadow_count > 0) issue_request(FUNC_POP, 1'b0, '0);
  endtask

  // Append at the bottom and read back from the top
  task automatic test_queue_order();
    wait_results_drained();
    set_queue_mode(1'b1);
    push_word(WORD_MIN);
    push_word(32'h5a5a_a5a5);
    push_word(WORD_MAX);
    push_word(32'h0000_0001);
    issue_request(FUNC_PEEK, 1'b0, '0);
    issue_request(FUNC_SWAP, 1'b1, '0);
    issue_request(FUNC_DUMP, 1'b0, '0);
    issue_request(FUNC_POP, 1'b0, '0);
    issue_request(FUNC_POP, 1'b0, '0);
    issue_request(FUNC_DUMP, 1'b0, '0);
    wait_results_drained();
    set_queue_mode(1'b0);
  endtask

  // Random traffic in segments, each with its own mode and push bias
  task automatic test_random_traffic();
    int          push_pct;
    int          roll;
    logic [2:0]  op;
    logic        arg;
    word_t       value;
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      wait_results_drained();
      send_gap_pct = (seg < 3) ? 28 : (seg < 6) ? 85 : 0;
      set_queue_mode(1'(seg % 2) ^ 1'($urandom_range(1) & (seg > 5)));
      push_pct = (seg % 3 == 0) ? 80 : (seg % 3 == 1) ? 50 : 30;
      for (int n = 0; n < SEGMENT_REQUESTS; n++) begin
        roll = $urandom_range(99);
        arg = 1'($urandom_range(1));
        case ($urandom_range(7))
          0:       value = WORD_MAX;
          1:       value = WORD_MIN;
          default: value = word_t'($urandom);
        endcase
        if (roll < push_pct) begin
          op = FUNC_PUSH;
          arg = ($urandom_range(15) != 0);
        end else begin
          case ($urandom_range(11))
            0:          op = FUNC_DUMP;
            1, 2, 3:    op = FUNC_PEEK;
            4, 5, 6, 7: op = FUNC_POP;
            8, 9, 10:   op = FUNC_SWAP;
            default:    op = 3'(FUNC_SWAP) + 3'($urandom_range(1, 3));
          endcase
        end
        issue_request(op, arg, value);
      end
    end
    send_gap_pct = 0;
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    stack_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result data=%h has_data=%b status=%0d last=%b",
                 $time, data_o, has_data_o, status_o, last_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (data_o !== want.data || has_data_o !== want.has_data ||
            status_o !== want.status || last_o !== want.last) begin
          $display("%0t: mismatch expected data=%h has_data=%b status=%0d last=%b",
                   $time, want.data, want.has_data, want.status, want.last);
          $display("%0t:          actual   data=%h has_data=%b status=%0d last=%b",
                   $time, data_o, has_data_o, status_o, last_o);
          error_count++;
        end
      end
    end
  end

  // End the run if nothing is accepted or returned for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_gap_pct = 28;
    test_empty_store();
    test_stack_extremes();
    test_full_store();
    test_queue_order();
    test_random_traffic();

    wait_results_drained();
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sqe_pkg.sv
rtl/core/sqe_mem.sv
rtl/core/sqe_ctrl.sv
rtl/core/stack_queue_engine_core.sv
rtl/core/sqe_checker.sv
dv/stack_queue_engine_core_tb.sv
